// File: rtl/fsl_pkg.sv
`timescale 1ns / 1ps

package fsl_pkg;

    // Default sizes of the pattern set.
    localparam int PATTERNS_DEF = 8;
    localparam int MAXLEN_DEF   = 64;

    // Item kinds carried on the input tuser.
    typedef enum logic [2:0] {
        KIND_PAT_BYTE  = 3'd0,
        KIND_PAT_CLR   = 3'd1,
        KIND_LINE_BYTE = 3'd2,
        KIND_EOL       = 3'd3,
        KIND_EOF       = 3'd4
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PATTERN_COUNT = 2'd0,
        REG_WHOLE_LINE    = 2'd1,
        REG_IGNORE_CASE   = 2'd2,
        REG_INVERT        = 2'd3
    } t_reg;

    // Report kinds on the output tuser.
    localparam logic REPORT_LINE = 1'b0;
    localparam logic REPORT_EOF  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pat_app;
        logic pat_clr;
        logic byte_take;
        logic scan;
        logic eol;
        logic eof;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } t_status;

    // ASCII fold to lower case when enabled.
    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

// File: rtl/fsl_ctrl.sv
`timescale 1ns / 1ps

module fsl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [2:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  fsl_pkg::t_status i_status,
    output fsl_pkg::t_cmd    o_cmd
);

    fsl_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            r_hold_eof, n_hold_eof;
    logic            accept;
    logic            out_free;
    fsl_pkg::t_kind  kind;

    assign kind       = fsl_pkg::t_kind'(i_s_tuser);
    assign o_s_tready = (r_state == fsl_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (kind == fsl_pkg::KIND_LINE_BYTE) begin
                        n_state = fsl_pkg::ST_SCAN;
                    end else if ((kind == fsl_pkg::KIND_EOL || kind == fsl_pkg::KIND_EOF)
                                 && !out_free) begin
                        n_state = fsl_pkg::ST_HOLD;
                    end
                end
            end
            fsl_pkg::ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = fsl_pkg::ST_IDLE;
                end
            end
            fsl_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = fsl_pkg::ST_IDLE;
                end
            end
            default: n_state = fsl_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            fsl_pkg::ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        fsl_pkg::KIND_PAT_BYTE:  o_cmd.pat_app   = 1'b1;
                        fsl_pkg::KIND_PAT_CLR:   o_cmd.pat_clr   = 1'b1;
                        fsl_pkg::KIND_LINE_BYTE: o_cmd.byte_take = 1'b1;
                        fsl_pkg::KIND_EOL:       o_cmd.eol       = out_free;
                        fsl_pkg::KIND_EOF:       o_cmd.eof       = out_free;
                        default: ;
                    endcase
                end
            end
            fsl_pkg::ST_SCAN: o_cmd.scan = 1'b1;
            fsl_pkg::ST_HOLD: begin
                o_cmd.eol = out_free && !r_hold_eof;
                o_cmd.eof = out_free && r_hold_eof;
            end
            default: ;
        endcase
    end

    // Output valid and the parked report kind.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.eol || o_cmd.eof) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        n_hold_eof = r_hold_eof;
        if (accept) begin
            n_hold_eof = (kind == fsl_pkg::KIND_EOF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_hold_eof  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hold_eof  <= n_hold_eof;
        end
    end

    // A pending result is never dropped.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("pending result lost");

    // A report is only loaded into a free output slot.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.eol || o_cmd.eof) |-> out_free)
        else $error("report overwrote a pending result");

    // The scan ends on its last update.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsl_pkg::ST_SCAN) && i_status.scan_last |=> (r_state == fsl_pkg::ST_IDLE))
        else $error("scan did not finish");

endmodule

// File: rtl/fsl_datapath.sv
`timescale 1ns / 1ps

module fsl_datapath #(
    parameter int PATTERNS = fsl_pkg::PATTERNS_DEF,
    parameter int MAXLEN   = fsl_pkg::MAXLEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsl_pkg::t_cmd    i_cmd,
    output fsl_pkg::t_status o_status,
    input  logic [7:0]       i_data,
    input  logic [2:0]       i_pattern_index,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [3:0]       i_cfg_data,
    output logic             o_report_kind,
    output logic             o_selected,
    output logic [31:0]      o_line_number,
    output logic [31:0]      o_selected_count,
    output logic             o_any_match
);

    localparam int PIW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int CW   = $clog2(PATTERNS + 1);
    localparam int LW   = (MAXLEN > 1) ? $clog2(MAXLEN) : 1;
    localparam int LENW = $clog2(MAXLEN + 1);
    localparam int POSW = $clog2(MAXLEN + 2);

    // Configuration registers.
    logic [3:0] r_pattern_count;
    logic       r_whole_line, r_ignore_case, r_invert;

    // Pattern memory, one row per pattern.
    logic [7:0] r_mem [PATTERNS][MAXLEN];
    logic [7:0] r_row [MAXLEN];

    logic [LENW-1:0]   r_len [PATTERNS];
    logic [MAXLEN-1:0] r_pm [PATTERNS];
    logic [PATTERNS-1:0] r_found, r_eq;
    logic [POSW-1:0]   r_pos;
    logic [31:0]       r_line_cnt, r_sel_cnt;
    logic              r_match_seen;

    logic [7:0]    r_byte;
    logic [CW-1:0] r_rd_idx;
    logic [PIW-1:0] r_upd_idx;
    logic          r_upd_vld;

    logic [6:0]     idx_ext;
    logic           idx_ok;
    logic [PIW-1:0] widx;
    logic           rd_go;
    logic           upd;

    logic [MAXLEN-1:0] hit, n_pm_row;
    logic [LENW-1:0]   upd_len;
    logic              n_found_bit, n_eq_bit;
    logic [LW-1:0]     pos_sel;

    logic [6:0]  used;
    logic        raw;
    logic        sel;
    logic [31:0] n_line_cnt, n_sel_cnt;

    assign idx_ext = {4'b0, i_pattern_index};
    assign idx_ok  = idx_ext < 7'(PATTERNS);
    assign widx    = idx_ext[PIW-1:0];
    assign rd_go   = i_cmd.scan && (r_rd_idx < CW'(PATTERNS));
    assign upd     = i_cmd.scan && r_upd_vld;
    assign o_status.scan_last = r_upd_vld && (r_rd_idx == CW'(PATTERNS));

    // Pattern memory write and registered row read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pat_app && idx_ok && r_len[widx] < LENW'(MAXLEN)) begin
            r_mem[widx][r_len[widx][LW-1:0]] <= i_data;
        end
        if (rd_go) begin
            r_row <= r_mem[r_rd_idx[PIW-1:0]];
        end
    end

    // Per-position compare cells for the pattern being updated.
    always_comb begin
        upd_len     = r_len[r_upd_idx];
        n_found_bit = 1'b0;
        for (int k = 0; k < MAXLEN; k++) begin
            hit[k] = fsl_pkg::fold(r_row[k], r_ignore_case) == r_byte;
            n_pm_row[k] = (LENW'(k) < upd_len) && hit[k]
                          && ((k == 0) ? 1'b1 : r_pm[r_upd_idx][(k > 0) ? k - 1 : 0]);
            if (LENW'(k + 1) == upd_len) begin
                n_found_bit = n_pm_row[k];
            end
        end
        pos_sel  = (r_pos < POSW'(MAXLEN)) ? r_pos[LW-1:0] : '0;
        n_eq_bit = !((r_pos >= POSW'(upd_len)) || !hit[pos_sel]);
    end

    // Line verdict over the patterns in use.
    always_comb begin
        used = ({3'b0, r_pattern_count} > 7'(PATTERNS)) ? 7'(PATTERNS)
                                                        : {3'b0, r_pattern_count};
        raw = 1'b0;
        for (int p = 0; p < PATTERNS; p++) begin
            if (7'(p) < used) begin
                if (r_whole_line) begin
                    raw = raw | (r_eq[p] && (r_pos == POSW'(r_len[p])));
                end else begin
                    raw = raw | r_found[p];
                end
            end
        end
        sel        = r_invert ? !raw : raw;
        n_line_cnt = (r_line_cnt != 32'hFFFF_FFFF) ? r_line_cnt + 32'd1 : r_line_cnt;
        n_sel_cnt  = (sel && r_sel_cnt != 32'hFFFF_FFFF) ? r_sel_cnt + 32'd1 : r_sel_cnt;
    end

    // Control and line state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_count <= 4'd1;
            r_whole_line    <= 1'b0;
            r_ignore_case   <= 1'b0;
            r_invert        <= 1'b0;
            for (int p = 0; p < PATTERNS; p++) begin
                r_len[p] <= '0;
                r_pm[p]  <= '0;
            end
            r_found      <= '0;
            r_eq         <= '1;
            r_pos        <= '0;
            r_line_cnt   <= '0;
            r_sel_cnt    <= '0;
            r_match_seen <= 1'b0;
            r_rd_idx     <= '0;
            r_upd_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (fsl_pkg::t_reg'(i_cfg_index))
                    fsl_pkg::REG_PATTERN_COUNT: r_pattern_count <= i_cfg_data;
                    fsl_pkg::REG_WHOLE_LINE:    r_whole_line    <= i_cfg_data[0];
                    fsl_pkg::REG_IGNORE_CASE:   r_ignore_case   <= i_cfg_data[0];
                    fsl_pkg::REG_INVERT:        r_invert        <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.pat_app && idx_ok && r_len[widx] < LENW'(MAXLEN)) begin
                r_len[widx] <= r_len[widx] + LENW'(1);
            end
            if (i_cmd.pat_clr && idx_ok) begin
                r_len[widx] <= '0;
            end
            // Scan pipeline: read row, then update the pattern's cells.
            if (i_cmd.byte_take) begin
                r_rd_idx  <= '0;
                r_upd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                if (rd_go) begin
                    r_rd_idx  <= r_rd_idx + CW'(1);
                    r_upd_vld <= 1'b1;
                end else begin
                    r_upd_vld <= 1'b0;
                end
            end
            if (upd) begin
                r_pm[r_upd_idx] <= n_pm_row;
                if (upd_len != '0 && n_found_bit) begin
                    r_found[r_upd_idx] <= 1'b1;
                end
                if (!n_eq_bit) begin
                    r_eq[r_upd_idx] <= 1'b0;
                end
            end
            if (upd && o_status.scan_last && r_pos <= POSW'(MAXLEN)) begin
                r_pos <= r_pos + POSW'(1);
            end
            // End of line and end of file.
            if (i_cmd.eol) begin
                r_line_cnt <= n_line_cnt;
                r_sel_cnt  <= n_sel_cnt;
                if (raw) begin
                    r_match_seen <= 1'b1;
                end
            end
            if (i_cmd.eof) begin
                r_line_cnt <= '0;
                r_sel_cnt  <= '0;
            end
            if (i_cmd.eol || i_cmd.eof) begin
                for (int p = 0; p < PATTERNS; p++) begin
                    r_pm[p] <= '0;
                end
                r_found <= '0;
                r_eq    <= '1;
                r_pos   <= '0;
            end
        end
    end

    // Scan byte and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_take) begin
            r_byte <= fsl_pkg::fold(i_data, r_ignore_case);
        end
        if (rd_go) begin
            r_upd_idx <= r_rd_idx[PIW-1:0];
        end
        if (i_cmd.eol) begin
            o_report_kind    <= fsl_pkg::REPORT_LINE;
            o_selected       <= sel;
            o_line_number    <= n_line_cnt;
            o_selected_count <= n_sel_cnt;
            o_any_match      <= r_match_seen | raw;
        end else if (i_cmd.eof) begin
            o_report_kind    <= fsl_pkg::REPORT_EOF;
            o_selected       <= 1'b0;
            o_line_number    <= r_line_cnt;
            o_selected_count <= r_sel_cnt;
            o_any_match      <= r_match_seen;
        end
    end

endmodule

// File: rtl/fixed_string_line_filter.sv
`timescale 1ns / 1ps

// Fixed-string line filter: pattern bytes and clears never hold off the input;
// a line byte does while the pattern memory delivers one pattern row per cycle
// to the compare cells, which update that pattern's partial matches across all
// positions at once. An end of line
// or end of file waits only while the previous report is still unclaimed.
module fixed_string_line_filter #(
    parameter int PATTERNS = fsl_pkg::PATTERNS_DEF,
    parameter int MAXLEN   = fsl_pkg::MAXLEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // data[7:0], pattern_index[10:8], zeros
    input  logic [2:0]  i_s_tuser,   // kind[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // selected[0], line_number[32:1],
                                     // selected_count[64:33], any_match[65], zeros
    output logic        o_m_tuser,   // report_kind[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    fsl_pkg::t_cmd    cmd;
    fsl_pkg::t_status status;
    logic             selected, any_match;
    logic [31:0]      line_number, selected_count;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {6'b0, any_match, selected_count, line_number, selected};

    fsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fsl_datapath #(
        .PATTERNS (PATTERNS),
        .MAXLEN   (MAXLEN)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_data           (i_s_tdata[7:0]),
        .i_pattern_index  (i_s_tdata[10:8]),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_report_kind    (o_m_tuser),
        .o_selected       (selected),
        .o_line_number    (line_number),
        .o_selected_count (selected_count),
        .o_any_match      (any_match)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NPAT     = fsl_pkg::PATTERNS_DEF;
    localparam int NLEN     = fsl_pkg::MAXLEN_DEF;
    // Settle time: four line-byte scans of all NPAT pattern rows, plus margin.
    localparam int SETTLE   = 4 * (NPAT + 2) + 10;
    localparam int PHASE_ITEMS = 210;

    typedef struct {
        bit        report;
        bit        sel;
        bit [31:0] line_no;
        bit [31:0] sel_cnt;
        bit        any;
    } t_verdict;

    // Line filter scoreboard: mirrors the pattern set and line state, and
    // keeps the verdicts and summaries still owed by the block.
    class t_line_filter_sb;
        bit [7:0]  store [NPAT][NLEN];
        int        plen  [NPAT];
        bit [NLEN-1:0] partial [NPAT];
        bit [NPAT-1:0] found;
        bit [NPAT-1:0] equal;
        int        pos;
        bit [31:0] lines;
        bit [31:0] picked;
        bit        seen;
        int        used_cfg;
        bit        whole_cfg;
        bit        fold_cfg;
        bit        inv_cfg;
        t_verdict  owed [$];
        int        errors;
        int        checked;
        int        eol_seen;
        int        eof_seen;

        function new();
            for (int p = 0; p < NPAT; p++) begin
                plen[p] = 0;
                partial[p] = '0;
            end
            found = '0;
            equal = '1;
            pos = 0;
            lines = 0;
            picked = 0;
            seen = 0;
            used_cfg = 1;
            whole_cfg = 0;
            fold_cfg = 0;
            inv_cfg = 0;
            errors = 0;
            checked = 0;
            eol_seen = 0;
            eof_seen = 0;
        endfunction

        function bit [7:0] lower(bit [7:0] c);
            if (fold_cfg && c >= 8'h41 && c <= 8'h5A) begin
                return c + 8'd32;
            end
            return c;
        endfunction

        function void set_reg(fsl_pkg::t_reg idx, bit [3:0] val);
            case (idx)
                fsl_pkg::REG_PATTERN_COUNT: used_cfg = int'(val);
                fsl_pkg::REG_WHOLE_LINE:    whole_cfg = val[0];
                fsl_pkg::REG_IGNORE_CASE:   fold_cfg = val[0];
                fsl_pkg::REG_INVERT:        inv_cfg = val[0];
                default: ;
            endcase
        endfunction

        function void new_line();
            for (int p = 0; p < NPAT; p++) begin
                partial[p] = '0;
            end
            found = '0;
            equal = '1;
            pos = 0;
        endfunction

        function void scan_byte(bit [7:0] b);
            bit [7:0] c;
            bit       prev;
            c = lower(b);
            for (int p = 0; p < NPAT; p++) begin
                for (int k = NLEN - 1; k >= 0; k--) begin
                    prev = (k == 0) ? 1'b1 : partial[p][k-1];
                    partial[p][k] = (k < plen[p]) && prev && (lower(store[p][k]) == c);
                end
                if (plen[p] > 0 && partial[p][plen[p]-1]) begin
                    found[p] = 1'b1;
                end
                if (pos >= plen[p] || lower(store[p][pos % NLEN]) != c) begin
                    equal[p] = 1'b0;
                end
            end
            if (pos <= NLEN) begin
                pos++;
            end
        endfunction

        function bit line_hit();
            int n;
            n = (used_cfg > NPAT) ? NPAT : used_cfg;
            for (int p = 0; p < n; p++) begin
                if (whole_cfg) begin
                    if (equal[p] && pos == plen[p]) return 1'b1;
                end else if (found[p]) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Update the mirror with one accepted input transaction.
        function void note_input(bit [2:0] kind, bit [7:0] data, bit [2:0] idx);
            t_verdict v;
            bit raw;
            case (kind)
                fsl_pkg::KIND_PAT_BYTE: begin
                    if (idx < NPAT && plen[idx] < NLEN) begin
                        store[idx][plen[idx]] = data;
                        plen[idx]++;
                    end
                end
                fsl_pkg::KIND_PAT_CLR: if (idx < NPAT) plen[idx] = 0;
                fsl_pkg::KIND_LINE_BYTE: scan_byte(data);
                fsl_pkg::KIND_EOL: begin
                    raw = line_hit();
                    v.sel = inv_cfg ? !raw : raw;
                    if (raw) seen = 1'b1;
                    if (lines != 32'hFFFF_FFFF) lines++;
                    if (v.sel && picked != 32'hFFFF_FFFF) picked++;
                    v.report = fsl_pkg::REPORT_LINE;
                    v.line_no = lines;
                    v.sel_cnt = picked;
                    v.any = seen;
                    owed.push_back(v);
                    new_line();
                end
                fsl_pkg::KIND_EOF: begin
                    v.report = fsl_pkg::REPORT_EOF;
                    v.sel = 1'b0;
                    v.line_no = lines;
                    v.sel_cnt = picked;
                    v.any = seen;
                    owed.push_back(v);
                    lines = 0;
                    picked = 0;
                    new_line();
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted output transaction with the oldest verdict owed.
        function void check_result(bit tuser, bit [71:0] tdata);
            t_verdict e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected report, tuser=%0b tdata=%h", $time, tuser, tdata);
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            if (e.report == fsl_pkg::REPORT_EOF) eof_seen++; else eol_seen++;
            if (tuser != e.report) begin
                $display("%0t: report_kind expected %0b actual %0b", $time, e.report, tuser);
                errors++;
            end
            if (tdata[0] != e.sel) begin
                $display("%0t: selected expected %0b actual %0b", $time, e.sel, tdata[0]);
                errors++;
            end
            if (tdata[32:1] != e.line_no) begin
                $display("%0t: line_number expected %0d actual %0d",
                         $time, e.line_no, tdata[32:1]);
                errors++;
            end
            if (tdata[64:33] != e.sel_cnt) begin
                $display("%0t: selected_count expected %0d actual %0d",
                         $time, e.sel_cnt, tdata[64:33]);
                errors++;
            end
            if (tdata[65] != e.any) begin
                $display("%0t: any_match expected %0b actual %0b", $time, e.any, tdata[65]);
                errors++;
            end
            if (tdata[71:66] != '0) begin
                $display("%0t: padding expected 0 actual %h", $time, tdata[71:66]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;

    t_line_filter_sb sb;
    bit calm = 1'b0;
    int sent = 0;
    int stall_left = 0;

    fixed_string_line_filter uut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("timeout with %0d reports still owed", sb.owed.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Output side: random back-pressure bursts, none in the calm part.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (calm) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Check every output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tuser, o_m_tdata);
        end
    end

    // Drive one input transaction; tvalid stays high into the next item
    // unless a gap is taken.
    task automatic send_item(fsl_pkg::t_kind kind, bit [7:0] data, bit [2:0] idx);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {5'd0, idx, data};
        i_s_tuser <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(kind, data, idx);
        sent++;
    endtask

    task automatic stop_input();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(fsl_pkg::t_reg idx, bit [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain all owed reports and let a pending line byte finish.
    task automatic drain();
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(bit [3:0] cnt, bit whole, bit nocase, bit inv);
        drain();
        write_reg(fsl_pkg::REG_PATTERN_COUNT, cnt);
        write_reg(fsl_pkg::REG_WHOLE_LINE, {3'b0, whole});
        write_reg(fsl_pkg::REG_IGNORE_CASE, {3'b0, nocase});
        write_reg(fsl_pkg::REG_INVERT, {3'b0, inv});
    endtask

    // Mostly a small alphabet so that patterns really occur in lines.
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h61;
            1: return 8'h41;
            2: return 8'h62;
            3: return 8'h42;
            4: return 8'h63;
            5: return 8'h5A;
            6: return 8'h7A;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_text(string s, fsl_pkg::t_kind kind, bit [2:0] idx);
        for (int i = 0; i < s.len(); i++) send_item(kind, s[i], idx);
    endtask

    task automatic random_phase(int target);
        int r;
        int n;
        int p;
        bit [7:0] b;
        fsl_pkg::t_kind k;
        target += sent;
        while (sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // Rewrite one pattern, occasionally past the length limit.
                p = $urandom_range(0, NPAT - 1);
                send_item(fsl_pkg::KIND_PAT_CLR, 8'($urandom_range(0, 255)), 3'(p));
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
                repeat (n) send_item(fsl_pkg::KIND_PAT_BYTE, pick_byte(), 3'(p));
            end else if (r < 10) begin
                k = fsl_pkg::t_kind'(3'($urandom_range(5, 7)));
                send_item(k, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            end else if (r < 13) begin
                k = fsl_pkg::t_kind'(3'($urandom_range(0, 1)));
                send_item(k, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
            end else if (r < 17) begin
                send_item(fsl_pkg::KIND_EOF, 8'($urandom_range(0, 255)),
                          3'($urandom_range(0, 7)));
            end else begin
                // A line built from copies of patterns and random bytes.
                n = $urandom_range(0, 3);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0) begin
                        p = $urandom_range(0, NPAT - 1);
                        for (int i = 0; i < sb.plen[p]; i++) begin
                            b = sb.store[p][i];
                            if ($urandom_range(0, 3) == 0 && b >= 8'h61 && b <= 8'h7A)
                                b = b - 8'd32;
                            send_item(fsl_pkg::KIND_LINE_BYTE, b, 3'($urandom_range(0, 7)));
                        end
                    end else begin
                        repeat ($urandom_range(1, 3))
                            send_item(fsl_pkg::KIND_LINE_BYTE, pick_byte(),
                                      3'($urandom_range(0, 7)));
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    send_item(fsl_pkg::KIND_EOL, 8'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)));
            end
        end
        stop_input();
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: substring hit and miss, empty line, zero and all-ones
        // bytes, unknown kinds, a clear of the last pattern index, end of file.
        send_text("ab", fsl_pkg::KIND_PAT_BYTE, 3'd0);
        send_text("xaby", fsl_pkg::KIND_LINE_BYTE, 3'd0);
        send_item(fsl_pkg::KIND_EOL, 8'h00, 3'd0);
        send_item(fsl_pkg::KIND_LINE_BYTE, 8'h00, 3'd7);
        send_item(fsl_pkg::KIND_LINE_BYTE, 8'hFF, 3'd7);
        send_item(fsl_pkg::KIND_EOL, 8'hFF, 3'd7);
        send_item(fsl_pkg::KIND_EOL, 8'h00, 3'd0);
        send_item(fsl_pkg::t_kind'(3'd5), 8'h61, 3'd0);
        send_item(fsl_pkg::t_kind'(3'd6), 8'h62, 3'd3);
        send_item(fsl_pkg::t_kind'(3'd7), 8'hFF, 3'd7);
        send_item(fsl_pkg::KIND_PAT_CLR, 8'h00, 3'd7);
        send_text("zz", fsl_pkg::KIND_LINE_BYTE, 3'd0);
        send_item(fsl_pkg::KIND_EOF, 8'h00, 3'd0);
        // Over-long pattern, and a line beyond the position limit.
        repeat (NLEN + 2) send_item(fsl_pkg::KIND_PAT_BYTE, 8'h41, 3'd1);
        stop_input();
        set_mode(4'd8, 1'b1, 1'b1, 1'b0);
        repeat (NLEN + 3) send_item(fsl_pkg::KIND_LINE_BYTE, 8'h61, 3'd0);
        send_item(fsl_pkg::KIND_EOL, 8'h00, 3'd0);
        repeat (NLEN) send_item(fsl_pkg::KIND_LINE_BYTE, 8'h61, 3'd0);
        send_item(fsl_pkg::KIND_EOL, 8'h00, 3'd0);
        // Empty pattern against an empty line in whole-line mode.
        send_item(fsl_pkg::KIND_PAT_CLR, 8'h00, 3'd2);
        send_item(fsl_pkg::KIND_EOL, 8'h00, 3'd0);
        // Unterminated line dropped at end of file.
        send_text("ab", fsl_pkg::KIND_LINE_BYTE, 3'd0);
        send_item(fsl_pkg::KIND_EOF, 8'h00, 3'd0);
        stop_input();

        set_mode(4'd8, 1'b0, 1'b0, 1'b0);
        random_phase(PHASE_ITEMS);
        set_mode(4'd8, 1'b1, 1'b0, 1'b0);
        random_phase(PHASE_ITEMS);
        set_mode(4'd3, 1'b0, 1'b1, 1'b1);
        random_phase(PHASE_ITEMS);
        set_mode(4'd15, 1'b1, 1'b1, 1'b0);
        random_phase(PHASE_ITEMS);
        set_mode(4'd0, 1'b0, 1'b0, 1'b1);
        random_phase(PHASE_ITEMS / 2);
        set_mode(4'd8, 1'b1, 1'b1, 1'b1);
        random_phase(PHASE_ITEMS);
        set_mode(4'd5, 1'b0, 1'b1, 1'b0);
        random_phase(PHASE_ITEMS);
        calm = 1'b1;
        set_mode(4'd8, 1'b0, 1'b0, 1'b0);
        random_phase(PHASE_ITEMS);

        drain();
        $display("Sent %0d input items over eight filter modes; checked %0d reports",
                 sent, sb.checked);
        $display("(%0d line verdicts, %0d end-of-file summaries).",
                 sb.eol_seen, sb.eof_seen);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/fsl_pkg.sv
rtl/fsl_ctrl.sv
rtl/fsl_datapath.sv
rtl/fixed_string_line_filter.sv
verif/tb.sv
